FILE: rtl/cfdf_pkg.sv
package cfdf_pkg;

   // Sizing of the seen-card table and the frame buffer.
   localparam int TABLE_ENTRIES = 16;
   localparam int ID_CHARS      = 12;
   localparam int FRAME_LIMIT   = 30;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int FCNT_W = $clog2(FRAME_LIMIT + 1);

   // Framing bytes and the two frame lengths that carry an ID.
   localparam logic [7:0] BYTE_START = 8'd2;
   localparam logic [7:0] BYTE_END   = 8'd3;
   localparam logic [3:0] SHORT_LEN  = 4'd10;
   localparam logic [3:0] LONG_LEN   = 4'd12;

   // Configuration register indexes and reset values.
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_WINDOW = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SILENT_WINDOW = 8'd1;
   localparam logic [31:0] REPEAT_WINDOW_RESET = 32'd300000;
   localparam logic [31:0] SILENT_WINDOW_RESET = 32'd4000;

   typedef enum logic [1:0] {
      VERDICT_ACCEPTED   = 2'd0,
      VERDICT_REPEAT     = 2'd1,
      VERDICT_SUPPRESSED = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [7:0]  rx_byte;
      logic [31:0] now_ms;
      logic        scan_enabled;
   } req_type;

   typedef struct packed {
      verdict_type verdict;
      logic [3:0]  id_length;
      logic [31:0] id_head;
      logic [63:0] id_tail;
   } rsp_type;

   // One row of the seen-card table.
   typedef struct packed {
      logic [31:0] head;
      logic [63:0] tail;
      logic        long_id;
      logic [31:0] time_ms;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic walk;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic end_ok;
      logic walk_last;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/card_frame_dedup_filter.sv
// Card reader frame assembler with repeat-scan filtering.
//
// Each request on the req_ channel carries one received byte, the current
// millisecond time and the scan enable flag. A start byte clears the frame, an
// end byte closes it, and other bytes are appended up to the frame limit.
// A request that closes a frame of 10 or 12 characters produces exactly one
// response on the rsp_ channel with the verdict and the packed ID; all other
// requests produce none. Two windows are set through the csr_ write channel,
// which is always ready and is meant to be written while the block is idle.
//
// A byte that does not close a valid frame leaves the block idle. A closing byte
// walks the seen-card table one entry per cycle through its single read port,
// then loads the response into the output register, and the block returns to
// idle to take the next request.
// The response sits in an output register; further bytes are still accepted
// while it waits, but the next frame end holds in its final step until the
// receiver has taken the previous response.
// Reset empties the table and the frame buffer and restores both windows.
module card_frame_dedup_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cfdf_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output cfdf_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cfdf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_wdata
);

   cfdf_pkg::ctrl_cmd_type  cmd;
   cfdf_pkg::dp_status_type status;

   // Register writes never stall.
   assign csr_ready = 1'b1;

   // The controller sequences accept, table walk and result hand-off.
   cfdf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .status   (status),
      .cmd      (cmd),
      .req_ready(req_ready)
   );

   // The datapath holds the frame, the table and the result register.
   cfdf_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Only one controller command is active at a time.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.walk, cmd.finish}))
      else $error("more than one controller command active");

   // A result is loaded only when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("result loaded over a pending response");

   // A valid frame end makes the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.end_ok) |=> (!req_ready && cmd.walk))
      else $error("frame end did not start a table walk");

   // Every response carries one of the two ID lengths.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.id_length == cfdf_pkg::SHORT_LEN) ||
                     (rsp_data.id_length == cfdf_pkg::LONG_LEN)))
      else $error("response with an illegal ID length");

endmodule

FILE: rtl/cfdf_ram.sv
module cfdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cfdf_ctrl.sv
module cfdf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  cfdf_pkg::dp_status_type status,
   output cfdf_pkg::ctrl_cmd_type  cmd,
   output logic                    req_ready
);

   cfdf_pkg::state_type state_ff;
   cfdf_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfdf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfdf_pkg::ST_IDLE: begin
            if (req_valid && status.end_ok) begin
               state_in = cfdf_pkg::ST_WALK;
            end
         end
         cfdf_pkg::ST_WALK: begin
            if (status.walk_last) begin
               state_in = cfdf_pkg::ST_FINISH;
            end
         end
         cfdf_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = cfdf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfdf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         cfdf_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         cfdf_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
         end
         cfdf_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: rtl/cfdf_dp.sv
module cfdf_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cfdf_pkg::ctrl_cmd_type               cmd,
   output cfdf_pkg::dp_status_type              status,
   input  cfdf_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cfdf_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   input  logic [cfdf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                          csr_wdata
);

   localparam int N      = cfdf_pkg::TABLE_ENTRIES;
   localparam int NCH    = cfdf_pkg::ID_CHARS;
   localparam int IDX_W  = cfdf_pkg::IDX_W;
   localparam int CNT_W  = cfdf_pkg::CNT_W;
   localparam int FCNT_W = cfdf_pkg::FCNT_W;
   localparam int ENTRY_BITS = cfdf_pkg::ENTRY_W;

   // Configuration.
   logic [31:0] repeat_ff, repeat_in;
   logic [31:0] silent_ff, silent_in;

   // Frame assembly.
   logic [7:0]        chars_ff [NCH];
   logic [7:0]        chars_in [NCH];
   logic [FCNT_W-1:0] count_ff, count_in;

   // The ID under test and its arrival time.
   logic [31:0] id_head_ff, id_head_in;
   logic [63:0] id_tail_ff, id_tail_in;
   logic        long_ff, long_in;
   logic [31:0] now_ff, now_in;

   // Table walk.
   logic [CNT_W-1:0] walk_cnt_ff, walk_cnt_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [N-1:0]     valid_ff, valid_in;
   logic             hit_found_ff, hit_found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [31:0]      hit_age_ff, hit_age_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             old_ok_ff, old_ok_in;
   logic [IDX_W-1:0] old_idx_ff, old_idx_in;
   logic [31:0]      old_age_ff, old_age_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   cfdf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic [7:0]          char_vis [NCH];
   logic [31:0]         pk_head;
   logic [63:0]         pk_tail;
   logic                walk_rd;
   logic [ENTRY_BITS-1:0] rd_data;
   cfdf_pkg::entry_type ent;
   logic [31:0]         age;
   logic                live;
   logic                stale;
   logic                match;
   logic                is_repeat;
   logic                is_quiet;
   logic [IDX_W-1:0]    slot;
   logic                wr_en;
   cfdf_pkg::entry_type wr_entry;
   cfdf_pkg::verdict_type verdict;

   // Characters past the count read as zero.
   always_comb begin
      for (int k = 0; k < NCH; k++) begin
         char_vis[k] = (FCNT_W'(k) < count_ff) ? chars_ff[k] : 8'd0;
      end
      pk_head = '0;
      pk_tail = '0;
      for (int k = 0; k < 4; k++) begin
         pk_head = {pk_head[23:0], char_vis[k]};
      end
      for (int k = 4; k < NCH; k++) begin
         pk_tail = {pk_tail[55:0], char_vis[k]};
      end
   end

   assign status.end_ok = req_data.scan_enabled && (req_data.rx_byte == cfdf_pkg::BYTE_END) &&
                          ((count_ff == FCNT_W'(cfdf_pkg::SHORT_LEN)) ||
                           (count_ff == FCNT_W'(cfdf_pkg::LONG_LEN)));
   assign status.walk_last = (walk_cnt_ff == CNT_W'(N));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign walk_rd = cmd.walk && (walk_cnt_ff < CNT_W'(N));

   // Per-entry evaluation on the registered read data.
   assign ent   = cfdf_pkg::entry_type'(rd_data);
   assign age   = now_ff - ent.time_ms;
   assign stale = valid_ff[chk_idx_ff] && (age > repeat_ff);
   assign live  = valid_ff[chk_idx_ff] && !(age > repeat_ff);
   assign match = (ent.head == id_head_ff) && (ent.tail == id_tail_ff) &&
                  (ent.long_id == long_ff);

   // Final decision once the walk is over.
   assign is_repeat = hit_found_ff && (hit_age_ff < repeat_ff);
   assign is_quiet  = is_repeat && (hit_age_ff < silent_ff);
   assign slot      = hit_found_ff ? hit_idx_ff : (free_found_ff ? free_idx_ff : old_idx_ff);
   assign wr_en     = cmd.finish && !is_quiet;

   always_comb begin
      if (is_quiet) begin
         verdict = cfdf_pkg::VERDICT_SUPPRESSED;
      end else if (is_repeat) begin
         verdict = cfdf_pkg::VERDICT_REPEAT;
      end else begin
         verdict = cfdf_pkg::VERDICT_ACCEPTED;
      end
      wr_entry.head    = id_head_ff;
      wr_entry.tail    = id_tail_ff;
      wr_entry.long_id = long_ff;
      wr_entry.time_ms = now_ff;
   end

   cfdf_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(N)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(slot),
      .wr_data(wr_entry),
      .rd_en  (walk_rd),
      .rd_addr(walk_cnt_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      repeat_in     = repeat_ff;
      silent_in     = silent_ff;
      chars_in      = chars_ff;
      count_in      = count_ff;
      id_head_in    = id_head_ff;
      id_tail_in    = id_tail_ff;
      long_in       = long_ff;
      now_in        = now_ff;
      walk_cnt_in   = walk_cnt_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      valid_in      = valid_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_age_in    = hit_age_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      old_ok_in     = old_ok_ff;
      old_idx_in    = old_idx_ff;
      old_age_in    = old_age_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_valid) begin
         if (csr_index == cfdf_pkg::CSR_REPEAT_WINDOW) begin
            repeat_in = csr_wdata;
         end else if (csr_index == cfdf_pkg::CSR_SILENT_WINDOW) begin
            silent_in = csr_wdata;
         end
      end

      if (cmd.accept) begin
         if (!req_data.scan_enabled || (req_data.rx_byte == cfdf_pkg::BYTE_START)) begin
            count_in = '0;
         end else if (req_data.rx_byte == cfdf_pkg::BYTE_END) begin
            count_in      = '0;
            id_head_in    = pk_head;
            id_tail_in    = pk_tail;
            long_in       = (count_ff == FCNT_W'(cfdf_pkg::LONG_LEN));
            now_in        = req_data.now_ms;
            walk_cnt_in   = '0;
            hit_found_in  = 1'b0;
            free_found_in = 1'b0;
            old_ok_in     = 1'b0;
            old_idx_in    = '0;
            old_age_in    = '0;
         end else if (count_ff < FCNT_W'(cfdf_pkg::FRAME_LIMIT)) begin
            for (int k = 0; k < NCH; k++) begin
               if (count_ff == FCNT_W'(k)) begin
                  chars_in[k] = req_data.rx_byte;
               end
            end
            count_in = count_ff + FCNT_W'(1);
         end
      end

      if (walk_rd) begin
         walk_cnt_in = walk_cnt_ff + CNT_W'(1);
         chk_vld_in  = 1'b1;
         chk_idx_in  = walk_cnt_ff[IDX_W-1:0];
      end

      if (chk_vld_ff) begin
         // Entries past the repeat window are aged out as the walk passes them.
         if (stale) begin
            valid_in[chk_idx_ff] = 1'b0;
         end
         if (live && match && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = chk_idx_ff;
            hit_age_in   = age;
         end
         if (!live && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = chk_idx_ff;
         end
         // Strictly greater keeps the lowest index on a tie.
         if (live && ((age > old_age_ff) || ((old_age_ff == '0) && !old_ok_ff))) begin
            old_ok_in  = 1'b1;
            old_idx_in = chk_idx_ff;
            old_age_in = age;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         if (wr_en) begin
            valid_in[slot] = 1'b1;
         end
         rsp_valid_in          = 1'b1;
         rsp_data_in.verdict   = verdict;
         rsp_data_in.id_length = long_ff ? cfdf_pkg::LONG_LEN : cfdf_pkg::SHORT_LEN;
         rsp_data_in.id_head   = id_head_ff;
         rsp_data_in.id_tail   = id_tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_ff    <= cfdf_pkg::REPEAT_WINDOW_RESET;
         silent_ff    <= cfdf_pkg::SILENT_WINDOW_RESET;
         count_ff     <= '0;
         walk_cnt_ff  <= '0;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         repeat_ff    <= repeat_in;
         silent_ff    <= silent_in;
         count_ff     <= count_in;
         walk_cnt_ff  <= walk_cnt_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff      <= chars_in;
      id_head_ff    <= id_head_in;
      id_tail_ff    <= id_tail_in;
      long_ff       <= long_in;
      now_ff        <= now_in;
      chk_idx_ff    <= chk_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_age_ff    <= hit_age_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      old_ok_ff     <= old_ok_in;
      old_idx_ff    <= old_idx_in;
      old_age_ff    <= old_age_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
